[rtl/ddb_pkg.sv]
// ----------------------------------------------------------------------------
// ddb_pkg: shared constants for the disc dilation bitmap
// field widths, action codes and parameter defaults
// ----------------------------------------------------------------------------
package ddb_pkg;

  localparam int ACTION_W = 2;
  localparam int COORD_W  = 9;
  localparam int RADIUS_W = 5;

  // disc diameter after reset, radius is half of it
  localparam int RESET_DIAMETER = 41;

  localparam int GRID_SIDE_DEF  = 512;
  localparam int WORD_BITS_DEF  = 64;
  localparam int MAX_RADIUS_DEF = 31;

  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

endpackage

[rtl/ddb_ram.sv]
// ----------------------------------------------------------------------------
// ddb_ram: generic single write, single read memory
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module ddb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/disc_dilation_bitmap.sv]
// ----------------------------------------------------------------------------
// disc_dilation_bitmap: occupancy bitmap of points dilated by a disc
// adds disc-shaped blobs into a square grid bitmap, reads single cells and
// clears the whole map; the bitmap lives in one word-wide memory
// ----------------------------------------------------------------------------
//
//  channel   | signals                          | handshake
//  ----------+----------------------------------+----------------------------
//  command   | action, x_coord, y_coord         | start high while busy low
//  result    | occupied, clipped                | done, one-cycle strobe
//  config    | cfg_data (radius)                | cfg_we, no wait, no readback
//
//  - a read goes through a memory read, then the result strobe
//  - an add walks the 2r+1 disc rows; each row runs the width-fit steps,
//    one span step and a read-modify-write per touched memory word
//  - a clear sweeps the memory one word per cycle, GRID_SIDE^2/WORD_BITS
//    words (4096 at default), then strobes done
//  - after reset the same sweep runs with busy high
//  - the receiver cannot stall: done is a strobe and results are never held
//
module disc_dilation_bitmap #(
  parameter int GRID_SIDE  = ddb_pkg::GRID_SIDE_DEF,
  parameter int WORD_BITS  = ddb_pkg::WORD_BITS_DEF,
  parameter int MAX_RADIUS = ddb_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // radius register
  input  logic                          cfg_we,
  input  logic [ddb_pkg::RADIUS_W-1:0]  cfg_data,
  // command word
  input  logic                          start,
  output logic                          busy,
  input  logic [ddb_pkg::ACTION_W-1:0]  action,
  input  logic [ddb_pkg::COORD_W-1:0]   x_coord,
  input  logic [ddb_pkg::COORD_W-1:0]   y_coord,
  // result word
  output logic                          done,
  output logic                          occupied,
  output logic                          clipped
);

  import ddb_pkg::*;

  // grid and word geometry (grid side and word size are powers of two)
  localparam int GSW   = $clog2(GRID_SIDE);
  localparam int WBW   = $clog2(WORD_BITS);
  localparam int WPR   = GRID_SIDE / WORD_BITS;          // words per row
  localparam int WPRW  = $clog2(WPR);
  localparam int CWW   = (WPRW > 0) ? WPRW : 1;          // word-in-row index
  localparam int DEPTH = GRID_SIDE * WPR;
  localparam int AW    = $clog2(DEPTH);
  // coordinate math: wide enough for the input field and the grid, plus sign
  localparam int XW    = (GSW > COORD_W) ? GSW : COORD_W;
  localparam int CW    = XW + 2;
  // radius and squares
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SQW   = 2 * RW;

  localparam logic signed [CW-1:0] GRID_S = CW'(GRID_SIDE);
  localparam logic [WORD_BITS-1:0] ONES   = {WORD_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_RD_DATA,
    S_FIT,
    S_SPAN,
    S_RMW_RD,
    S_RMW_WR
  } state_t;

  state_t state;

  // config and control
  logic [RADIUS_W-1:0] radius;
  logic [AW-1:0]       sweep_addr;
  logic                report_clear;

  // add / read working registers
  logic [XW-1:0]        cx;
  logic [XW-1:0]        cy;
  logic                 rd_ok;
  logic [RW-1:0]        r_q;
  logic [SQW-1:0]       rr;
  logic signed [RW:0]   dy;
  logic [SQW-1:0]       dysq;
  logic [RW-1:0]        w;
  logic [SQW-1:0]       wsq;
  logic                 clip;
  logic [GSW-1:0]       row_q;
  logic [WBW-1:0]       lo_off_q;
  logic [WBW-1:0]       hi_off_q;
  logic [CWW-1:0]       lo_w;
  logic [CWW-1:0]       hi_w;
  logic [CWW-1:0]       wk;

  // memory ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign busy = (state != S_IDLE);

  // ---------------------------------------------------------------------------
  // radius clamp and its square, taken once when an add starts
  // ---------------------------------------------------------------------------
  logic [RW-1:0]  r_eff;
  logic [SQW-1:0] r_sq;

  always_comb begin
    if (int'(radius) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius);
    end
    r_sq = SQW'(r_eff) * SQW'(r_eff);
  end

  // ---------------------------------------------------------------------------
  // width fit: moves w up or down by one step per cycle
  // until w is the largest half-width with w^2 + dy^2 <= r^2
  // ---------------------------------------------------------------------------
  logic [SQW+1:0] fit_base;
  logic [SQW+1:0] two_w1;
  logic           fit_w;
  logic           fit_up;
  logic [SQW-1:0] wsq_up;
  logic [SQW-1:0] wsq_dn;

  always_comb begin
    fit_base = {2'b00, wsq} + {2'b00, dysq};
    two_w1   = (SQW+2)'({w, 1'b1});
    fit_w    = (fit_base <= {2'b00, rr});
    fit_up   = ((fit_base + two_w1) <= {2'b00, rr}) && (w < r_q);
    wsq_up   = SQW'({2'b00, wsq} + two_w1);
    wsq_dn   = SQW'({2'b00, wsq} - two_w1 + (SQW+2)'(2));
  end

  // ---------------------------------------------------------------------------
  // next disc row: dy steps up by one, dy^2 follows incrementally
  // ---------------------------------------------------------------------------
  logic                 last_row;
  logic signed [SQW+1:0] dy_ext;
  logic signed [SQW+1:0] dysq_s;

  always_comb begin
    last_row = (dy == $signed({1'b0, r_q}));
    dy_ext   = (SQW+2)'(dy);
    dysq_s   = $signed({2'b00, dysq}) + dy_ext + dy_ext + (SQW+2)'(1);
  end

  // ---------------------------------------------------------------------------
  // row span: clip the row and its column range to the grid
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] yy;
  logic signed [CW-1:0] lo;
  logic signed [CW-1:0] hi;
  logic                 row_on;
  logic                 lo_clip;
  logic                 hi_clip;
  logic                 span_empty;
  logic [GSW-1:0]       lo_c;
  logic [GSW-1:0]       hi_c;

  always_comb begin
    yy         = $signed({2'b00, cy}) + CW'(dy);
    lo         = $signed({2'b00, cx}) - $signed(CW'(w));
    hi         = $signed({2'b00, cx}) + $signed(CW'(w));
    row_on     = (yy >= 0) && (yy < GRID_S);
    lo_clip    = (lo < 0);
    hi_clip    = (hi >= GRID_S);
    span_empty = (lo >= GRID_S);
    lo_c       = lo_clip ? '0 : lo[GSW-1:0];
    hi_c       = hi_clip ? GSW'(GRID_SIDE - 1) : hi[GSW-1:0];
  end

  // ---------------------------------------------------------------------------
  // word mask for the current word of the span
  // ---------------------------------------------------------------------------
  logic [WBW-1:0]       lo_off;
  logic [WBW-1:0]       hi_off;
  logic [WORD_BITS-1:0] span_mask;

  always_comb begin
    lo_off    = (wk == lo_w) ? lo_off_q : '0;
    hi_off    = (wk == hi_w) ? hi_off_q : WBW'(WORD_BITS - 1);
    span_mask = (ONES << lo_off) & (ONES >> (~hi_off));
  end

  // ---------------------------------------------------------------------------
  // memory address and write muxes
  // ---------------------------------------------------------------------------
  logic [XW-1:0] x_in;
  logic [XW-1:0] y_in;
  logic [AW-1:0] rmw_addr;

  always_comb begin
    x_in     = XW'(x_coord);
    y_in     = XW'(y_coord);
    rmw_addr = (AW'(row_q) << WPRW) | AW'(wk);
    // idle: a read command goes straight to the memory
    if (state == S_IDLE) begin
      ram_raddr = (AW'(y_in[GSW-1:0]) << WPRW) | AW'(x_in[GSW-1:0] >> WBW);
    end else begin
      ram_raddr = rmw_addr;
    end
    ram_we = (state == S_SWEEP) || (state == S_RMW_WR);
    if (state == S_SWEEP) begin
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_waddr = rmw_addr;
      ram_wdata = ram_rdata | span_mask;
    end
  end

  ddb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_SWEEP;
      sweep_addr   <= '0;
      report_clear <= 1'b0;
      done         <= 1'b0;
      radius       <= RADIUS_W'(RESET_DIAMETER / 2);
    end else begin
      if (cfg_we) begin
        radius <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cx    <= x_in;
            cy    <= y_in;
            rd_ok <= (int'(x_coord) < GRID_SIDE) && (int'(y_coord) < GRID_SIDE);
            unique case (action)
              ACT_ADD: begin
                done  <= 1'b0;
                r_q   <= r_eff;
                rr    <= r_sq;
                dy    <= -$signed({1'b0, r_eff});
                dysq  <= r_sq;
                w     <= '0;
                wsq   <= '0;
                clip  <= 1'b0;
                state <= S_FIT;
              end
              ACT_READ: begin
                done  <= 1'b0;
                state <= S_RD_DATA;
              end
              ACT_CLEAR: begin
                done         <= 1'b0;
                sweep_addr   <= '0;
                report_clear <= 1'b1;
                state        <= S_SWEEP;
              end
              default: begin
                // unused code: no effect, zero result
                done     <= 1'b1;
                occupied <= 1'b0;
                clipped  <= 1'b0;
              end
            endcase
          end else begin
            done <= 1'b0;
          end
        end
        S_SWEEP: begin
          sweep_addr <= sweep_addr + AW'(1);
          if (sweep_addr == AW'(DEPTH - 1)) begin
            state        <= S_IDLE;
            report_clear <= 1'b0;
            done         <= report_clear;
            if (report_clear) begin
              occupied <= 1'b0;
              clipped  <= 1'b0;
            end
          end else begin
            done <= 1'b0;
          end
        end
        S_RD_DATA: begin
          done     <= 1'b1;
          occupied <= rd_ok & ram_rdata[cx[WBW-1:0]];
          clipped  <= 1'b0;
          state    <= S_IDLE;
        end
        S_FIT: begin
          done <= 1'b0;
          if (!fit_w) begin
            w   <= w - RW'(1);
            wsq <= wsq_dn;
          end else if (fit_up) begin
            w   <= w + RW'(1);
            wsq <= wsq_up;
          end else begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (!row_on || lo_clip || hi_clip) begin
            clip <= 1'b1;
          end
          if (row_on && !span_empty) begin
            done     <= 1'b0;
            row_q    <= yy[GSW-1:0];
            lo_off_q <= lo_c[WBW-1:0];
            hi_off_q <= hi_c[WBW-1:0];
            lo_w     <= CWW'(lo_c >> WBW);
            hi_w     <= CWW'(hi_c >> WBW);
            wk       <= CWW'(lo_c >> WBW);
            state    <= S_RMW_RD;
          end else if (last_row) begin
            done     <= 1'b1;
            occupied <= 1'b0;
            clipped  <= clip | !row_on | lo_clip | hi_clip;
            state    <= S_IDLE;
          end else begin
            done  <= 1'b0;
            dy    <= dy + (RW+1)'(1);
            dysq  <= dysq_s[SQW-1:0];
            state <= S_FIT;
          end
        end
        S_RMW_RD: begin
          // read data shows up in the next cycle
          done  <= 1'b0;
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (wk != hi_w) begin
            done  <= 1'b0;
            wk    <= wk + CWW'(1);
            state <= S_RMW_RD;
          end else if (last_row) begin
            done     <= 1'b1;
            occupied <= 1'b0;
            clipped  <= clip;
            state    <= S_IDLE;
          end else begin
            done  <= 1'b0;
            dy    <= dy + (RW+1)'(1);
            dysq  <= dysq_s[SQW-1:0];
            state <= S_FIT;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_half_width: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIT) |-> (w <= r_q))
    else $error("half-width beyond radius");

  a_word_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW_WR) |-> (wk <= hi_w && wk >= lo_w))
    else $error("span word outside row span");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SWEEP || state == S_RMW_WR))
    else $error("memory write outside sweep or update");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("not sweeping after reset");

  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> !(occupied && clipped))
    else $error("read and add flags both set");

endmodule

[dv/disc_map_check.sv]
// ----------------------------------------------------------------------------
// disc_map_check: result checker for the disc dilation bitmap
// watches the command, result and radius channels, keeps its own copy of
// the bitmap, predicts each result word and compares it field by field
// ----------------------------------------------------------------------------
module disc_map_check
  import ddb_pkg::*;
#(
  parameter int GRID_SIDE  = GRID_SIDE_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  parameter int REPORT_CAP = 200
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RADIUS_W-1:0] cfg_data,
  input  logic                start,
  input  logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [COORD_W-1:0]  x_coord,
  input  logic [COORD_W-1:0]  y_coord,
  input  logic                done,
  input  logic                occupied,
  input  logic                clipped,
  output int                  words_pending,
  output int                  fault_count
);

  typedef struct packed {
    logic occupied;
    logic clipped;
  } reply_t;

  bit [GRID_SIDE-1:0] occ_rows [GRID_SIDE];
  int                 radius_q;
  reply_t             replies_due [$];
  int                 faults = 0;

  function automatic void wipe_map();
    foreach (occ_rows[i]) occ_rows[i] = '0;
  endfunction

  // stamp the disc into the map, return 1 if any disc cell is off the grid
  function automatic bit stamp_disc(int cx, int cy);
    int r;
    int rr;
    int px;
    int py;
    bit off_grid;
    r = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
    rr = r * r;
    off_grid = 1'b0;
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        if (dx * dx + dy * dy <= rr) begin
          px = cx + dx;
          py = cy + dy;
          if (px >= 0 && py >= 0 && px < GRID_SIDE && py < GRID_SIDE) begin
            occ_rows[py][px] = 1'b1;
          end else begin
            off_grid = 1'b1;
          end
        end
      end
    end
    return off_grid;
  endfunction

  function automatic void note_fault(string what, int want, int got);
    faults++;
    if (faults <= REPORT_CAP) begin
      $error("%s mismatch: expected %0d, got %0d", what, want, got);
    end
    if (faults == REPORT_CAP) begin
      $display("fault report cap reached, further faults only counted");
    end
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      wipe_map();
      radius_q = RESET_DIAMETER / 2;
      replies_due.delete();
    end else begin
      // result side first: a word accepted here was predicted earlier
      if (done) begin
        if (replies_due.size() == 0) begin
          note_fault("unexpected result word", 0, 1);
        end else begin
          want = replies_due.pop_front();
          if (want.occupied !== occupied) note_fault("occupied", want.occupied, occupied);
          if (want.clipped !== clipped) note_fault("clipped", want.clipped, clipped);
        end
      end
      if (cfg_we) radius_q = cfg_data;
      if (start && !busy) begin
        want = '0;
        case (action)
          ACT_ADD:   want.clipped = stamp_disc(x_coord, y_coord);
          ACT_READ:  want.occupied = occ_rows[y_coord][x_coord];
          ACT_CLEAR: wipe_map();
          default: ;
        endcase
        replies_due.insert(replies_due.size(), want);
      end
    end
    words_pending <= replies_due.size();
    fault_count   <= faults;
  end

endmodule

[dv/tb_disc_dilation_bitmap.sv]
// ----------------------------------------------------------------------------
// tb_disc_dilation_bitmap: testbench top for the disc dilation bitmap
// directed centre and corner commands, then random add/read/clear/spare traffic over several
// radius settings and sender idle rates; a checker predicts every result
// ----------------------------------------------------------------------------
module tb_disc_dilation_bitmap;
  import ddb_pkg::*;

  // action code the block must answer with an all-zero word
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE = 102;
  localparam int SETTLE_CYCLES   = 64;
  // slowest legal run: every command a clear (a full memory sweep) plus long
  // sender gaps, ~1560 commands, then a few times over for margin
  localparam longint CYCLE_LIMIT = 20_000_000;

  logic                clk;
  logic                rst      = 1'b1;
  logic                cfg_we   = 1'b0;
  logic [RADIUS_W-1:0] cfg_data = '0;
  logic                start    = 1'b0;
  logic [ACTION_W-1:0] action   = '0;
  logic [COORD_W-1:0]  x_coord  = '0;
  logic [COORD_W-1:0]  y_coord  = '0;
  logic                busy;
  logic                done;
  logic                occupied;
  logic                clipped;

  int     words_pending;
  int     fault_count;
  longint cycle_count = 0;

  int radius_now = RESET_DIAMETER / 2;
  int n_add      = 0;
  int n_read     = 0;
  int n_clear    = 0;
  int n_spare    = 0;
  int n_radius   = 0;

  // recent add centres, packed {x, y}, so reads land inside the discs
  logic [2*COORD_W-1:0] recent_pts [$];

  disc_dilation_bitmap dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .done     (done),
    .occupied (occupied),
    .clipped  (clipped)
  );

  disc_map_check u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .done          (done),
    .occupied      (occupied),
    .clipped       (clipped),
    .words_pending (words_pending),
    .fault_count   (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one command word and hold it until the block takes it
  task automatic send_cmd(logic [ACTION_W-1:0] act, logic [COORD_W-1:0] x,
                          logic [COORD_W-1:0] y);
    start   <= 1'b1;
    action  <= act;
    x_coord <= x;
    y_coord <= y;
    do @(posedge clk); while (busy);
    case (act)
      ACT_ADD:   n_add++;
      ACT_READ:  n_read++;
      ACT_CLEAR: n_clear++;
      default:   n_spare++;
    endcase
  endtask

  // random sender gap, geometric in length
  task automatic pause_sender(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // stop sending until every predicted word is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (words_pending != 0 || busy);
  endtask

  // radius writes only happen on an idle block
  task automatic set_radius(int r);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= r[RADIUS_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    radius_now = r;
    n_radius++;
  endtask

  // coordinate scattered around c, clamped onto the grid
  function automatic logic [COORD_W-1:0] near_coord(int c, int reach);
    int v;
    v = c + $urandom_range(2 * reach) - reach;
    if (v < 0) v = 0;
    else if (v > GRID_SIDE_DEF - 1) v = GRID_SIDE_DEF - 1;
    return v[COORD_W-1:0];
  endfunction

  // coordinate close to either border, so discs get clipped
  function automatic logic [COORD_W-1:0] rim_coord();
    int v;
    v = $urandom_range(1) ? $urandom_range(40) : GRID_SIDE_DEF - 1 - $urandom_range(40);
    return v[COORD_W-1:0];
  endfunction

  task automatic random_cmd();
    int                   pick;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [2*COORD_W-1:0] pt;
    pick = $urandom_range(99);
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    if (pick < 2) begin
      send_cmd(ACT_CLEAR, x, y);
    end else if (pick < 6) begin
      send_cmd(ACT_SPARE, x, y);
    end else if (pick < 40) begin
      // adds: a quarter of each axis hugs a border
      if ($urandom_range(3) == 0) x = rim_coord();
      if ($urandom_range(3) == 0) y = rim_coord();
      recent_pts.insert(recent_pts.size(), {x, y});
      if (recent_pts.size() > 8) void'(recent_pts.pop_front());
      send_cmd(ACT_ADD, x, y);
    end else begin
      // reads: mostly probe around a recent centre, hitting the disc rim
      if (recent_pts.size() > 0 && $urandom_range(9) < 7) begin
        pt = recent_pts[$urandom_range(recent_pts.size() - 1)];
        x = near_coord(pt[2*COORD_W-1:COORD_W], radius_now + 2);
        y = near_coord(pt[COORD_W-1:0], radius_now + 2);
      end
      send_cmd(ACT_READ, x, y);
    end
  endtask

  initial begin : stimulus
    int idle_pct;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset radius 20: disc centre, rim along an axis and diagonal
    send_cmd(ACT_ADD,  9'd256, 9'd256);
    send_cmd(ACT_READ, 9'd256, 9'd256);
    send_cmd(ACT_READ, 9'd276, 9'd256);
    send_cmd(ACT_READ, 9'd277, 9'd256);
    send_cmd(ACT_READ, 9'd270, 9'd270);
    send_cmd(ACT_READ, 9'd271, 9'd270);
    // corner adds clip on two sides
    send_cmd(ACT_ADD,  9'd0,   9'd0);
    send_cmd(ACT_READ, 9'd0,   9'd0);
    send_cmd(ACT_ADD,  9'd511, 9'd511);
    send_cmd(ACT_READ, 9'd511, 9'd511);
    send_cmd(ACT_READ, 9'd491, 9'd511);
    // unused action with all-ones coordinates changes nothing
    send_cmd(ACT_SPARE, 9'd511, 9'd511);
    send_cmd(ACT_READ, 9'd0,   9'd511);
    send_cmd(ACT_CLEAR, 9'd511, 9'd511);
    send_cmd(ACT_READ, 9'd256, 9'd256);

    // zero radius: only the point itself
    set_radius(0);
    send_cmd(ACT_ADD,  9'd511, 9'd0);
    send_cmd(ACT_READ, 9'd511, 9'd0);
    send_cmd(ACT_READ, 9'd510, 9'd0);
    send_cmd(ACT_ADD,  9'd0,   9'd511);

    // largest radius: just fits at (31,31), clips one column further in
    set_radius(31);
    send_cmd(ACT_ADD,  9'd31,  9'd31);
    send_cmd(ACT_ADD,  9'd30,  9'd480);
    send_cmd(ACT_READ, 9'd0,   9'd31);
    send_cmd(ACT_READ, 9'd62,  9'd31);
    send_cmd(ACT_SPARE, 9'd0,  9'd0);
    send_cmd(ACT_CLEAR, 9'd0,  9'd0);

    // random traffic: light sender idling, heavy idling, then back to back
    for (int mode = 0; mode < 3; mode++) begin
      idle_pct = (mode == 0) ? 15 : (mode == 1) ? 82 : 0;
      for (int phase = 0; phase < 5; phase++) begin
        case (phase)
          0:       set_radius(0);
          1:       set_radius(31);
          default: set_radius($urandom_range(1, 30));
        endcase
        repeat (ITEMS_PER_PHASE) begin
          pause_sender(idle_pct);
          random_cmd();
          // now and then let the block run dry before the next word
          if ($urandom_range(99) == 0) drain();
        end
      end
    end

    drain();
    // catch stray result words after the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d commands: %0d adds, %0d reads, %0d clears, %0d unused actions",
             n_add + n_read + n_clear + n_spare, n_add, n_read, n_clear, n_spare);
    $display("over %0d radius settings incl. 0 and 31, sender idle 15%%, 82%% and none",
             n_radius);
    if (fault_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
